### rtl/pbet_pkg.sv
// ----------------------------------------------------------------------------
// pbet_pkg
// shared types, event codes, mode codes and register map of the key event
// tracker
// ----------------------------------------------------------------------------
package pbet_pkg;

   // event codes
   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_DOWN   = 3'd1;
   localparam logic [2:0] EV_READY  = 3'd2;
   localparam logic [2:0] EV_PRESS  = 3'd3;
   localparam logic [2:0] EV_REPEAT = 3'd4;
   localparam logic [2:0] EV_UP     = 3'd5;
   localparam logic [2:0] EV_DONE   = 3'd6;

   // key mode codes
   localparam logic [2:0] MODE_UP     = 3'd0;
   localparam logic [2:0] MODE_DOWN   = 3'd1;
   localparam logic [2:0] MODE_READY  = 3'd2;
   localparam logic [2:0] MODE_PRESS  = 3'd3;
   localparam logic [2:0] MODE_REPEAT = 3'd4;

   // register indexes (byte address 4*i)
   localparam logic [2:0] REG_TRACK_MASK = 3'd0;
   localparam logic [2:0] REG_READY_TIME = 3'd1;
   localparam logic [2:0] REG_LONG_TIME  = 3'd2;
   localparam logic [2:0] REG_REPEAT     = 3'd3;
   localparam logic [2:0] REG_DONE_TIME  = 3'd4;

   localparam int unsigned ADDR_W = 5;

   // reset values
   localparam logic [7:0]  TRACK_MASK_RST = 8'hFF;
   localparam logic [15:0] READY_TIME_RST = 16'd50;
   localparam logic [15:0] LONG_TIME_RST  = 16'd1000;
   localparam logic [15:0] REPEAT_RST     = 16'd200;
   localparam logic [15:0] DONE_TIME_RST  = 16'd500;
   localparam logic [7:0]  PINS_RST       = 8'hFF;
   localparam logic [7:0]  COUNT_MAX      = 8'hFF;

   typedef struct packed {
      logic [7:0]  track_mask;
      logic [15:0] ready_time;
      logic [15:0] long_press_time;
      logic [15:0] repeat_time;
      logic [15:0] done_time;
   } cfg_type;

   typedef struct packed {
      logic [2:0] event_type;
      logic [7:0] event_data;
   } event_type_type;

endpackage

### rtl/pbet_csr.sv
// ----------------------------------------------------------------------------
// pbet_csr
// apb-style register file holding the track mask and timing thresholds
// ----------------------------------------------------------------------------
module pbet_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pbet_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output pbet_pkg::cfg_type           cfg
);

   pbet_pkg::cfg_type cfg_ff;
   pbet_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index  = paddr[pbet_pkg::ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            pbet_pkg::REG_TRACK_MASK: cfg_in.track_mask      = pwdata[7:0];
            pbet_pkg::REG_READY_TIME: cfg_in.ready_time      = pwdata[15:0];
            pbet_pkg::REG_LONG_TIME:  cfg_in.long_press_time = pwdata[15:0];
            pbet_pkg::REG_REPEAT:     cfg_in.repeat_time     = pwdata[15:0];
            pbet_pkg::REG_DONE_TIME:  cfg_in.done_time       = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         pbet_pkg::REG_TRACK_MASK: prdata = {24'd0, cfg_ff.track_mask};
         pbet_pkg::REG_READY_TIME: prdata = {16'd0, cfg_ff.ready_time};
         pbet_pkg::REG_LONG_TIME:  prdata = {16'd0, cfg_ff.long_press_time};
         pbet_pkg::REG_REPEAT:     prdata = {16'd0, cfg_ff.repeat_time};
         pbet_pkg::REG_DONE_TIME:  prdata = {16'd0, cfg_ff.done_time};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.track_mask      <= pbet_pkg::TRACK_MASK_RST;
         cfg_ff.ready_time      <= pbet_pkg::READY_TIME_RST;
         cfg_ff.long_press_time <= pbet_pkg::LONG_TIME_RST;
         cfg_ff.repeat_time     <= pbet_pkg::REPEAT_RST;
         cfg_ff.done_time       <= pbet_pkg::DONE_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/pbet_core.sv
// ----------------------------------------------------------------------------
// pbet_core
// key tracking state and the per-sample event decision
// ----------------------------------------------------------------------------
module pbet_core (
   input  logic                     clock,
   input  logic                     reset,
   input  pbet_pkg::cfg_type        cfg,
   input  logic                     step_en,
   input  logic [7:0]               pins,
   input  logic [15:0]              now,
   output pbet_pkg::event_type_type evt
);

   logic [7:0]  pin_levels_ff,   pin_levels_in;
   logic [7:0]  tracked_keys_ff, tracked_keys_in;
   logic [2:0]  key_mode_ff,     key_mode_in;
   logic [7:0]  repeat_count_ff, repeat_count_in;
   logic [15:0] down_stamp_ff,   down_stamp_in;
   logic [15:0] press_stamp_ff,  press_stamp_in;

   logic [7:0]  changed;
   logic [7:0]  low;
   logic [7:0]  held;
   logic [7:0]  count_inc;
   logic [15:0] since_down;
   logic [15:0] since_press;

   assign changed     = pin_levels_ff ^ pins;
   assign low         = changed & (~changed + 8'd1);
   assign held        = (pin_levels_ff ^ cfg.track_mask) & cfg.track_mask;
   assign since_down  = now - down_stamp_ff;
   assign since_press = now - press_stamp_ff;
   assign count_inc   = (repeat_count_ff == pbet_pkg::COUNT_MAX) ?
                        repeat_count_ff : repeat_count_ff + 8'd1;

   always_comb begin
      pin_levels_in   = pin_levels_ff;
      tracked_keys_in = tracked_keys_ff;
      key_mode_in     = key_mode_ff;
      repeat_count_in = repeat_count_ff;
      down_stamp_in   = down_stamp_ff;
      press_stamp_in  = press_stamp_ff;
      evt.event_type  = pbet_pkg::EV_NONE;
      evt.event_data  = tracked_keys_ff;

      if (changed != 8'd0) begin
         // edge on the pins: report lowest changed pin
         down_stamp_in   = now;
         pin_levels_in   = pins;
         tracked_keys_in = low;
         evt.event_data  = low;
         if ((pins & changed) != 8'd0) begin
            if (key_mode_ff == pbet_pkg::MODE_READY) begin
               evt.event_type = pbet_pkg::EV_PRESS;
               key_mode_in    = pbet_pkg::MODE_PRESS;
            end else begin
               evt.event_type = pbet_pkg::EV_UP;
               key_mode_in    = pbet_pkg::MODE_UP;
            end
         end else begin
            evt.event_type = pbet_pkg::EV_DOWN;
            key_mode_in    = pbet_pkg::MODE_DOWN;
         end
      end else begin
         unique case (key_mode_ff)
            pbet_pkg::MODE_PRESS: begin
               key_mode_in    = pbet_pkg::MODE_UP;
               evt.event_type = pbet_pkg::EV_UP;
            end
            pbet_pkg::MODE_UP: begin
               evt.event_data = 8'd0;
               if (held != 8'd0) begin
                  // keys still held: done is dropped, go to ready
                  key_mode_in     = pbet_pkg::MODE_READY;
                  down_stamp_in   = now;
                  tracked_keys_in = held;
               end else if (tracked_keys_ff != 8'd0 && since_down >= cfg.done_time) begin
                  tracked_keys_in = 8'd0;
                  evt.event_type  = pbet_pkg::EV_DONE;
                  evt.event_data  = tracked_keys_ff;
               end
            end
            pbet_pkg::MODE_DOWN: begin
               if (since_down >= cfg.ready_time) begin
                  repeat_count_in = 8'd0;
                  key_mode_in     = pbet_pkg::MODE_READY;
                  press_stamp_in  = now;
                  evt.event_type  = pbet_pkg::EV_READY;
               end
            end
            pbet_pkg::MODE_READY: begin
               if (since_down >= cfg.long_press_time) begin
                  key_mode_in     = pbet_pkg::MODE_REPEAT;
                  repeat_count_in = count_inc;
                  down_stamp_in   = now;
                  evt.event_type  = pbet_pkg::EV_REPEAT;
                  evt.event_data  = count_inc;
               end
            end
            pbet_pkg::MODE_REPEAT: begin
               if (since_down >= cfg.long_press_time) begin
                  repeat_count_in = count_inc;
                  down_stamp_in   = now;
                  evt.event_type  = pbet_pkg::EV_REPEAT;
                  evt.event_data  = count_inc;
               end else if (since_press >= cfg.repeat_time) begin
                  press_stamp_in = now;
                  evt.event_type = pbet_pkg::EV_PRESS;
                  evt.event_data = held;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_levels_ff   <= pbet_pkg::PINS_RST;
         tracked_keys_ff <= 8'd0;
         key_mode_ff     <= pbet_pkg::MODE_UP;
         repeat_count_ff <= 8'd0;
         down_stamp_ff   <= 16'd0;
         press_stamp_ff  <= 16'd0;
      end else if (step_en) begin
         pin_levels_ff   <= pin_levels_in;
         tracked_keys_ff <= tracked_keys_in;
         key_mode_ff     <= key_mode_in;
         repeat_count_ff <= repeat_count_in;
         down_stamp_ff   <= down_stamp_in;
         press_stamp_ff  <= press_stamp_in;
      end
   end

endmodule

### rtl/push_button_event_tracker.sv
// ----------------------------------------------------------------------------
// push_button_event_tracker
// turns samples of eight active-low key pins plus a millisecond stamp into
// down, ready, press, repeat, up and done events
// ----------------------------------------------------------------------------
//
//   channel | direction | beat contents               | handshake
//   --------+-----------+-----------------------------+-------------------------
//   req     | in        | pins[7:0], now[15:0]        | req_valid / req_ready
//   rsp     | out       | event_type[2:0], data[7:0]  | rsp_valid / rsp_ready
//   csr     | in/out    | 5 registers at 4*i          | psel/penable, pready=1
//
// - one beat in, one event out; a new beat can enter every cycle while rsp is not stalled
// - a beat passes through the input register, then the event decision into the
//   result register
// - the tracker state advances as a beat leaves the input register, so the
//   next beat sees it in the following cycle
// - a stalled rsp holds the result; one more beat can still wait in the
//   input register before req_ready drops
// - reset is synchronous: empties both stages and restores the configuration registers and tracker state
//
module push_button_event_tracker (
   input  logic                        clock,
   input  logic                        reset,
   // sample beats
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_pins,
   input  logic [15:0]                 req_now,
   // event beats
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_event_type,
   output logic [7:0]                  rsp_event_data,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pbet_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   pbet_pkg::cfg_type        cfg;
   pbet_pkg::event_type_type evt;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_pins_ff;
   logic [15:0] in_now_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_type_ff;
   logic [7:0]  rsp_data_ff;

   logic advance;   // result stage can take a new event
   logic step;      // a beat moves from input to result stage

   pbet_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pbet_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (step),
      .pins    (in_pins_ff),
      .now     (in_now_ff),
      .evt     (evt)
   );

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign step      = in_valid_ff & advance;
   // input register is free when empty or when it drains this cycle
   assign req_ready = ~in_valid_ff | advance;

   assign in_valid_in  = (req_valid & req_ready) | (in_valid_ff & ~advance);
   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_pins_ff <= req_pins;
         in_now_ff  <= req_now;
      end
      if (step) begin
         rsp_type_ff <= evt.event_type;
         rsp_data_ff <= evt.event_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_type = rsp_type_ff;
   assign rsp_event_data = rsp_data_ff;

   // a beat leaving the input stage always lands in the result stage
   a_step_lands : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("decided event lost");

   // input side never blocks while the result stage is empty
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("req_ready low with empty result stage");

   // a waiting sample is not overwritten
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_now_ff)
                                     && $stable(in_pins_ff)))
      else $error("waiting sample overwritten");

   // repeat events always carry a nonzero count
   a_repeat_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_type_ff == pbet_pkg::EV_REPEAT) |-> rsp_data_ff != 8'd0)
      else $error("repeat event with zero count");

endmodule

### dv/tb_push_button_event_tracker.sv
// ----------------------------------------------------------------------------
// tb_push_button_event_tracker
// self-checking bench for the key event tracker: drives pin samples with
// running millisecond stamps, predicts each event in a scoreboard class and
// compares every event beat field by field, across several register settings
// ----------------------------------------------------------------------------
module tb_push_button_event_tracker;

   localparam int unsigned STALL_LIMIT = 2000;  // cycles without any beat
   localparam int unsigned LONG_HOLD   = 64;    // long rsp back-pressure
   localparam int unsigned ITEM_TOTAL  = 1000;

   // -------------------------------------------------------------------------
   // scoreboard: own copy of tracker state and registers, queue of events due
   // -------------------------------------------------------------------------
   class event_scoreboard;
      logic [7:0]                track_mask;
      logic [15:0]               ready_time, long_time, repeat_time, done_time;
      logic [7:0]                pin_levels, tracked, repeat_count;
      logic [2:0]                key_mode;
      logic [15:0]               down_stamp, press_stamp;
      pbet_pkg::event_type_type  due_events[$];
      int unsigned               mismatches;

      function new();
         track_mask   = pbet_pkg::TRACK_MASK_RST;
         ready_time   = pbet_pkg::READY_TIME_RST;
         long_time    = pbet_pkg::LONG_TIME_RST;
         repeat_time  = pbet_pkg::REPEAT_RST;
         done_time    = pbet_pkg::DONE_TIME_RST;
         pin_levels   = pbet_pkg::PINS_RST;
         tracked      = 8'h00;
         repeat_count = 8'h00;
         key_mode     = pbet_pkg::MODE_UP;
         down_stamp   = 16'h0000;
         press_stamp  = 16'h0000;
         mismatches   = 0;
      endfunction

      function void apply_reg(logic [2:0] index, logic [15:0] value);
         case (index)
            pbet_pkg::REG_TRACK_MASK: track_mask  = value[7:0];
            pbet_pkg::REG_READY_TIME: ready_time  = value;
            pbet_pkg::REG_LONG_TIME:  long_time   = value;
            pbet_pkg::REG_REPEAT:     repeat_time = value;
            pbet_pkg::REG_DONE_TIME:  done_time   = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_events.size();
      endfunction

      function logic [7:0] held_keys();
         return (pin_levels ^ track_mask) & track_mask;
      endfunction

      // time since a stamp, wrapping at 16 bits
      function logic [15:0] since(logic [15:0] stamp, logic [15:0] then);
         logic [15:0] diff;
         diff = stamp - then;
         return diff;
      endfunction

      function pbet_pkg::event_type_type make_event(logic [2:0] kind, logic [7:0] data);
         pbet_pkg::event_type_type ev;
         ev.event_type = kind;
         ev.event_data = data;
         return ev;
      endfunction

      function pbet_pkg::event_type_type bump_repeat(logic [15:0] stamp);
         if (repeat_count != pbet_pkg::COUNT_MAX) repeat_count = repeat_count + 8'd1;
         down_stamp = stamp;
         return make_event(pbet_pkg::EV_REPEAT, repeat_count);
      endfunction

      function pbet_pkg::event_type_type predict_event(logic [7:0] pins,
                                                       logic [15:0] stamp);
         logic [7:0] changed, lowest, done_keys;
         pbet_pkg::event_type_type ev;
         if (pins != pin_levels) begin
            changed    = pin_levels ^ pins;
            lowest     = changed & (~changed + 8'd1);
            down_stamp = stamp;
            if ((pins & changed) != 8'h00) begin
               if (key_mode == pbet_pkg::MODE_READY) begin
                  ev       = make_event(pbet_pkg::EV_PRESS, lowest);
                  key_mode = pbet_pkg::MODE_PRESS;
               end else begin
                  ev       = make_event(pbet_pkg::EV_UP, lowest);
                  key_mode = pbet_pkg::MODE_UP;
               end
            end else begin
               ev       = make_event(pbet_pkg::EV_DOWN, lowest);
               key_mode = pbet_pkg::MODE_DOWN;
            end
            pin_levels = pins;
            tracked    = lowest;
         end else if (key_mode == pbet_pkg::MODE_PRESS) begin
            key_mode = pbet_pkg::MODE_UP;
            ev       = make_event(pbet_pkg::EV_UP, tracked);
         end else if (key_mode == pbet_pkg::MODE_UP) begin
            ev = make_event(pbet_pkg::EV_NONE, 8'h00);
            if (tracked != 8'h00 && since(stamp, down_stamp) >= done_time) begin
               done_keys = tracked;
               tracked   = held_keys();
               if (tracked == 8'h00) ev = make_event(pbet_pkg::EV_DONE, done_keys);
            end
            // keys still down after a release re-enter the ready mode
            if (held_keys() != 8'h00) begin
               key_mode   = pbet_pkg::MODE_READY;
               down_stamp = stamp;
               tracked    = held_keys();
            end
         end else if (key_mode == pbet_pkg::MODE_DOWN &&
                      since(stamp, down_stamp) >= ready_time) begin
            repeat_count = 8'h00;
            key_mode     = pbet_pkg::MODE_READY;
            press_stamp  = stamp;
            ev           = make_event(pbet_pkg::EV_READY, tracked);
         end else if (key_mode == pbet_pkg::MODE_READY &&
                      since(stamp, down_stamp) >= long_time) begin
            key_mode = pbet_pkg::MODE_REPEAT;
            ev       = bump_repeat(stamp);
         end else if (key_mode == pbet_pkg::MODE_REPEAT &&
                      since(stamp, down_stamp) >= long_time) begin
            ev = bump_repeat(stamp);
         end else if (key_mode == pbet_pkg::MODE_REPEAT &&
                      since(stamp, press_stamp) >= repeat_time) begin
            press_stamp = stamp;
            ev          = make_event(pbet_pkg::EV_PRESS, held_keys());
         end else begin
            ev = make_event(pbet_pkg::EV_NONE, tracked);
         end
         return ev;
      endfunction

      function void note_sample(logic [7:0] pins, logic [15:0] stamp);
         due_events.push_back(predict_event(pins, stamp));
      endfunction

      function void report(string what, int unsigned want, int unsigned got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      endfunction

      function void check_event(logic [2:0] kind, logic [7:0] data);
         pbet_pkg::event_type_type want;
         if (due_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("event type %0d data 'h%0h with nothing pending", kind, data);
         end else begin
            want = due_events.pop_front();
            if (kind !== want.event_type)
               report("event_type", 32'(want.event_type), 32'(kind));
            if (data !== want.event_data)
               report("event_data", 32'(want.event_data), 32'(data));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals
   // -------------------------------------------------------------------------
   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [7:0]                    req_pins;
   logic [15:0]                   req_now;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [2:0]                    rsp_event_type;
   logic [7:0]                    rsp_event_data;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [pbet_pkg::ADDR_W-1:0]   paddr;
   logic [31:0]                   pwdata;
   logic [31:0]                   prdata;
   logic                          pready;

   event_scoreboard sb;

   // sender-side bookkeeping, owned by the stimulus process
   logic [15:0]         stamp_ms;     // running millisecond clock
   logic [7:0]          pin_state;    // pins of the last sample sent
   int unsigned         sent;

   bit                  no_idle;      // both sides run without gaps
   int unsigned         hold_asks;    // long receiver stalls asked for so far

   push_button_event_tracker DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pins       (req_pins),
      .req_now        (req_now),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_type (rsp_event_type),
      .rsp_event_data (rsp_event_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gap before a beat; half the beats go back to back even when idling
   function automatic int unsigned draw_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 16);
   endfunction

   // -------------------------------------------------------------------------
   // sample driver
   // -------------------------------------------------------------------------
   // called at a rising edge; valid is only lowered when a gap follows, so a
   // back-to-back beat never sees a low and a high in the same step
   task automatic send_sample(input logic [7:0] pins, input logic [15:0] stamp);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pins  <= pins;
      req_now   <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(pins, stamp);
      sent++;
   endtask

   // advance the millisecond clock and send a sample
   task automatic step(input logic [7:0] pins, input int unsigned delta);
      stamp_ms  = stamp_ms + 16'(delta);
      pin_state = pins;
      send_sample(pins, stamp_ms);
   endtask

   // stop offering beats and let every event drain out
   task automatic quiesce(input int unsigned settle);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // register port: setup cycle then access cycle, pready always high
   // -------------------------------------------------------------------------
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.apply_reg(index, value);
   endtask

   task automatic set_config(input logic [7:0] mask, input logic [15:0] ready_ms,
                             input logic [15:0] long_ms, input logic [15:0] repeat_ms,
                             input logic [15:0] done_ms);
      // every beat yields one event, so once the queue is empty the block is
      // idle; the settle cycles add margin
      quiesce(4);
      write_reg(pbet_pkg::REG_TRACK_MASK, {8'h00, mask});
      write_reg(pbet_pkg::REG_READY_TIME, ready_ms);
      write_reg(pbet_pkg::REG_LONG_TIME, long_ms);
      write_reg(pbet_pkg::REG_REPEAT, repeat_ms);
      write_reg(pbet_pkg::REG_DONE_TIME, done_ms);
   endtask

   // one press/hold/release gesture with random timing, or a burst of noise
   task automatic run_gesture(input int unsigned step_max);
      logic [7:0]  keys;
      int unsigned holds;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
         // noise: arbitrary pins at arbitrary stamps
         repeat ($urandom_range(1, 4)) begin
            stamp_ms = 16'($urandom);
            step(8'($urandom), 0);
         end
      end else begin
         // mostly a single key, sometimes a chord
         if ($urandom_range(0, 3) == 0) keys = 8'($urandom);
         else keys = 8'(1 << $urandom_range(0, 7));
         if (pin_state != 8'hFF) step(8'hFF, $urandom_range(0, step_max));
         step(8'hFF, $urandom_range(0, step_max));
         step(~keys, $urandom_range(0, step_max));
         holds = $urandom_range(0, 12);
         repeat (holds) begin
            // occasionally one pin flips while the others stay held
            if ($urandom_range(0, 9) == 0)
               step(pin_state ^ 8'(1 << $urandom_range(0, 7)), $urandom_range(0, step_max));
            else
               step(pin_state, $urandom_range(0, step_max));
         end
         step(8'hFF, $urandom_range(0, step_max));
         // quiet tail so done events get a chance to fire
         repeat ($urandom_range(0, 5)) step(8'hFF, $urandom_range(0, step_max));
      end
   endtask

   // -------------------------------------------------------------------------
   // event receiver
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned pause;
      int unsigned holds_done;
      holds_done = 0;
      rsp_ready  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asks != holds_done) begin
            // long back-pressure so the block fills up and stalls req
            pause = LONG_HOLD;
            holds_done++;
         end else begin
            pause = draw_gap();
         end
         if (pause != 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_event(rsp_event_type, rsp_event_data);
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: too long with no beat on either channel ends the run
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pins  = 8'h00;
      req_now   = 16'h0000;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = 32'h0;
      stamp_ms  = 16'h0000;
      pin_state = 8'hFF;
      sent      = 0;
      no_idle   = 1'b0;
      hold_asks = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values: ready 50, long 1000, repeat 200,
      // done 500, all keys tracked
      step(8'hFF, 0);        // quiet in up mode with nothing tracked
      step(8'hFE, 10);       // key 0 down
      step(8'hFE, 60);       // held past ready time
      step(8'hFF, 10);       // short press: release from ready
      step(8'hFF, 1);        // press mode falls back to up
      step(8'hFF, 600);      // done after the release
      step(8'hFE, 10);       // key 0 down again
      step(8'hFE, 50);       // ready exactly at the threshold
      step(8'hFE, 1000);     // first long-press repeat
      step(8'hFE, 250);      // auto-repeat press
      step(8'hFE, 800);      // second repeat
      step(8'hFF, 5);        // release out of repeat mode
      step(8'hFF, 5);        // quiet before done time
      step(8'h00, 5);        // all pins at once: only the lowest is reported
      step(8'h80, 60);       // one pin up among many: counts as a release
      step(8'h80, 600);      // done dropped because keys are still held
      step(8'h80, 1000);     // held keys now ready, long press repeat
      step(8'hFF, 3);        // release of the rest
      step(8'hFF, 4);        // quiet
      step(8'hFF, 16'hFFF0); // stamp wraps, done fires on the wrapped diff
      step(8'h7F, 2);        // top pin down
      step(8'hFF, 2);        // top pin up

      // short times; receiver stalls hard while the sender keeps pushing
      set_config(8'hFF, 16'd4, 16'd30, 16'd6, 16'd20);
      hold_asks++;
      no_idle = 1'b1;
      step(8'hFF, 1);
      repeat (8) step(8'hF7, 1);
      while (sent < 240) run_gesture(12);

      // zero times: every quiet step repeats, count runs into saturation
      set_config(8'hFF, 16'd0, 16'd0, 16'd0, 16'd0);
      no_idle = 1'b0;
      step(8'hFF, 1);
      step(8'hFB, 1);
      repeat (270) step(8'hFB, $urandom_range(0, 3));
      step(8'hFF, 1);
      while (sent < 560) run_gesture(3);

      // largest times and no tracked keys: only an exact full-wrap diff fires
      set_config(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      step(8'hFD, 1);
      step(8'hFD, 16'hFFFF); // ready exactly at a full wrap
      step(8'hFD, 1);
      step(8'hFF, 1);
      step(8'hFF, 1);
      step(8'hFF, 16'hFFFF); // no done: a full wrap brings the diff back to zero
      while (sent < 640) run_gesture(30000);

      // random mask and short random times
      set_config(8'($urandom), 16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                 16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
      while (sent < 820) run_gesture(20);

      // random mask and longer random times
      set_config(8'($urandom), 16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                 16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
      while (sent < ITEM_TOTAL) run_gesture(120);

      quiesce(8);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/pbet_pkg.sv
rtl/pbet_csr.sv
rtl/pbet_core.sv
rtl/push_button_event_tracker.sv
dv/tb_push_button_event_tracker.sv
